### hw/rtl/stacked_arena_bump_allocator_top_defines.svh
// Assertion macros for the allocator
`ifndef STACKED_ARENA_BUMP_ALLOCATOR_TOP_DEFINES_SVH
`define STACKED_ARENA_BUMP_ALLOCATOR_TOP_DEFINES_SVH
`define SAB_ASSERT_IMP(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("assertion failed");
`define SAB_ASSERT_NXT(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("assertion failed");
`endif

### hw/rtl/sab_pkg.sv
// ---------------------------------------------------------------------------
// sab_pkg
// Shared types and constants of the stacked arena allocator.
// ---------------------------------------------------------------------------
package sab_pkg;
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TOO_LARGE = 2'd1;
    localparam logic [1:0] ST_NO_ARENA  = 2'd2;
    localparam logic [1:0] ST_BAD_FREE  = 2'd3;
    localparam logic       REQ_ALLOC    = 1'b0;
    localparam logic       REQ_FREE     = 1'b1;

    typedef enum logic [2:0] {
        OP_ADD = 3'b001,
        OP_SUB = 3'b010,
        OP_PASS = 3'b100
    } t_alu_op;

    typedef struct packed {
        t_alu_op     op;
        logic [31:0] a;
        logic [31:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [32:0] sum;
    } t_alu_rsp;
endpackage

### hw/rtl/sab_alu.sv
// ---------------------------------------------------------------------------
// sab_alu
// Shared adder and subtractor used by the read and address steps of the sequencer.
// ---------------------------------------------------------------------------
module sab_alu (
    input  sab_pkg::t_alu_req i_req,
    output sab_pkg::t_alu_rsp o_rsp
);
    import sab_pkg::*;

    always_comb begin
        unique case (i_req.op)
            OP_ADD:  o_rsp.sum = {1'b0, i_req.a} + {1'b0, i_req.b};
            OP_SUB:  o_rsp.sum = {1'b0, i_req.a} - {1'b0, i_req.b};
            OP_PASS: o_rsp.sum = {1'b0, i_req.a};
            default: o_rsp.sum = '0;
        endcase
    end
endmodule

### hw/rtl/stacked_arena_bump_allocator_top.sv
// Each request runs through a small sequencer around one shared adder: read the
// stack tops, fetch the arena entry, check, form the address, update, respond.
// A rejected request (too large, no free arena, free outside the region) goes
// from the check straight to respond, and a free skips forming the address.
// A free that drains its arena walks the arena stack instead, popping empty
// arenas until the stack is empty or a live arena is on top. The sequencer
// goes back to idle as the result word appears and takes the next request
// word in the cycle after. The result waits in an output register, and the
// sequencer holds in its respond step only while an earlier result is still
// stalled there. No clearing pass is needed after reset.
// ---------------------------------------------------------------------------
// stacked_arena_bump_allocator_top
// Bump allocator over a stack of fixed-size arenas with a free-slot stack.
// ---------------------------------------------------------------------------
module stacked_arena_bump_allocator_top #(
    parameter int ARENA_BYTES = 65536,
    parameter int ARENA_SLOTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_req_type,
    input  logic [31:0] i_size_bytes,
    input  logic [31:0] i_block_address,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_granted_address,
    output logic [1:0]  o_status,
    output logic [22:0] o_bytes_in_use
);
    import sab_pkg::*;
    `include "stacked_arena_bump_allocator_top_defines.svh"

    localparam int SW = $clog2(ARENA_SLOTS);
    localparam int CW = SW + 1;
    localparam int AW = $clog2(ARENA_BYTES);
    localparam int FW = AW + 1;
    localparam int LW = AW - 3;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_READ  = 10'b0000000010,
        S_FETCH = 10'b0000000100,
        S_CHECK = 10'b0000001000,
        S_ADDR  = 10'b0000010000,
        S_UPD   = 10'b0000100000,
        S_POPRD = 10'b0001000000,
        S_POPLV = 10'b0010000000,
        S_POPCK = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    t_state r_state;
    logic [31:0] r_base, r_size, r_addr, r_gaddr, r_offset;
    logic        r_type;
    logic [1:0]  r_status;
    logic [CW-1:0] r_depth, r_fcnt;
    logic [22:0] r_held;
    logic        r_ovld;
    logic [SW-1:0] r_slot, r_top, r_fslot;
    logic        r_push;
    logic [FW-1:0] r_fill;
    logic [LW-1:0] r_live_rd;

    logic [SW-1:0] m_astk [ARENA_SLOTS];
    logic [SW-1:0] m_fstk [ARENA_SLOTS];
    logic [FW-1:0] m_fill [ARENA_SLOTS];
    logic [LW-1:0] m_live [ARENA_SLOTS];
    logic [ARENA_SLOTS-1:0] r_lvalid;
    logic [ARENA_SLOTS-1:0] r_fvalid;

    t_alu_req alu_req;
    t_alu_rsp alu_rsp;
    sab_alu u_alu (.i_req(alu_req), .o_rsp(alu_rsp));

    logic [32:0] need;
    logic [31:0] sz1;
    logic        too_large;
    assign sz1  = (r_size == 32'd0) ? 32'd1 : r_size;
    assign need = ({1'b0, sz1} + 33'd15) & ~33'd15;
    assign too_large = need >= 33'(ARENA_BYTES);

    logic [SW-1:0] fidx;
    assign fidx = r_fcnt[SW-1:0] - SW'(1);

    logic in_range;
    logic [SW-1:0] free_slot;
    logic [SW-1:0] fetch_slot;
    logic          out_free;
    assign in_range   = 64'(r_offset) < 64'(ARENA_SLOTS) * 64'(ARENA_BYTES);
    assign free_slot  = SW'(r_offset >> AW);
    assign fetch_slot = (r_type == REQ_FREE) ? free_slot : r_top;
    assign out_free   = !r_ovld || !i_out_stall;

    always_comb begin
        alu_req = '{op: OP_PASS, a: 32'd0, b: 32'd0};
        unique case (r_state)
            S_READ:  alu_req = '{op: OP_SUB, a: r_addr, b: r_base};
            S_ADDR:  alu_req = '{op: OP_ADD, a: r_base,
                                 b: 32'(r_slot) << AW | 32'(r_fill)};
            default: alu_req = '{op: OP_PASS, a: 32'd0, b: 32'd0};
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_base <= '0; r_depth <= '0;
            r_fcnt <= CW'(ARENA_SLOTS); r_held <= '0; r_ovld <= 1'b0;
            r_lvalid <= '0; r_fvalid <= '0;
        end else begin
            if (i_cfg_we) r_base <= i_cfg_wdata;
            if (r_state == S_OUT && out_free) r_ovld <= 1'b1;
            else if (!i_out_stall) r_ovld <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_in_valid && !o_in_stall) begin
                    r_type <= i_req_type; r_size <= i_size_bytes;
                    r_addr <= i_block_address; r_state <= S_READ;
                end
                S_READ: begin
                    r_top <= m_astk[r_depth[SW-1:0] - SW'(1)];
                    r_fslot <= r_fvalid[fidx] ? m_fstk[fidx] :
                               SW'(ARENA_SLOTS - int'(r_fcnt));
                    r_offset <= alu_rsp.sum[31:0];
                    r_state <= S_FETCH;
                end
                S_FETCH: begin
                    r_slot <= fetch_slot;
                    r_fill <= m_fill[fetch_slot];
                    r_live_rd <= r_lvalid[fetch_slot] ? m_live[fetch_slot] : '0;
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (r_type == REQ_FREE) begin
                        r_status <= in_range ? ST_OK : ST_BAD_FREE;
                        r_state <= in_range ? S_UPD : S_OUT;
                    end else if (too_large) begin
                        r_status <= ST_TOO_LARGE;
                        r_state <= S_OUT;
                    end else if (r_depth == '0 ||
                                 33'(r_fill) + need > 33'(ARENA_BYTES)) begin
                        if (r_fcnt == '0 || r_depth >= CW'(ARENA_SLOTS)) begin
                            r_status <= ST_NO_ARENA;
                            r_state <= S_OUT;
                        end else begin
                            r_status <= ST_OK;
                            r_slot <= r_fslot; r_fill <= '0; r_push <= 1'b1;
                            r_live_rd <= '0; r_state <= S_ADDR;
                        end
                    end else begin
                        r_status <= ST_OK; r_push <= 1'b0; r_state <= S_ADDR;
                    end
                end
                S_ADDR: begin
                    r_gaddr <= alu_rsp.sum[31:0];
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (r_type == REQ_ALLOC) begin
                        if (r_push) begin
                            m_astk[r_depth[SW-1:0]] <= r_slot;
                            r_depth <= r_depth + CW'(1);
                            r_fcnt <= r_fcnt - CW'(1);
                            r_held <= r_held + 23'(ARENA_BYTES);
                        end
                        m_fill[r_slot] <= r_fill + FW'(need);
                        m_live[r_slot] <= r_live_rd + LW'(1);
                        r_lvalid[r_slot] <= 1'b1;
                        r_state <= S_OUT;
                    end else if (r_live_rd == '0) begin
                        r_status <= ST_BAD_FREE;
                        r_state <= S_OUT;
                    end else begin
                        m_live[r_slot] <= r_live_rd - LW'(1);
                        r_lvalid[r_slot] <= 1'b1;
                        r_state <= (r_live_rd == LW'(1)) ? S_POPRD : S_OUT;
                    end
                end
                S_POPRD: begin
                    if (r_depth == '0) r_state <= S_OUT;
                    else begin
                        r_top <= m_astk[r_depth[SW-1:0] - SW'(1)];
                        r_state <= S_POPLV;
                    end
                end
                S_POPLV: begin
                    r_live_rd <= r_lvalid[r_top] ? m_live[r_top] : '0;
                    r_state <= S_POPCK;
                end
                S_POPCK: begin
                    if (r_live_rd != '0) r_state <= S_OUT;
                    else begin
                        r_depth <= r_depth - CW'(1);
                        m_fstk[r_fcnt[SW-1:0]] <= r_top;
                        r_fvalid[r_fcnt[SW-1:0]] <= 1'b1;
                        r_fcnt <= r_fcnt + CW'(1);
                        r_held <= r_held - 23'(ARENA_BYTES);
                        r_state <= S_POPRD;
                    end
                end
                S_OUT: if (out_free) begin
                    o_granted_address <= (r_status == ST_OK && r_type == REQ_ALLOC)
                                         ? r_gaddr : 32'd0;
                    o_status <= r_status; o_bytes_in_use <= r_held;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_ovld;

    `SAB_ASSERT_IMP(a_fcnt_le, i_clk, i_rst_n, 1'b1, r_fcnt <= CW'(ARENA_SLOTS))
    `SAB_ASSERT_IMP(a_sum, i_clk, i_rst_n, 1'b1,
        int'(r_fcnt) + int'(r_depth) == ARENA_SLOTS)
    `SAB_ASSERT_NXT(a_busy, i_clk, i_rst_n, r_state == S_OUT, r_ovld)
endmodule
